// ===== sv/linear_blend_skinning_assert.svh =====
// ----------------------------------------------------------------------------
// linear blend skinning assertion macros
// assertion wrappers that can be compiled out
// ----------------------------------------------------------------------------
`ifndef LINEAR_BLEND_SKINNING_ASSERT_SVH
`define LINEAR_BLEND_SKINNING_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define LBS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LBS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LBS_ASSERT_IMPL(label, ante, cons, msg)
`define LBS_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== sv/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg
// shared types and constants of the skinning block
// ----------------------------------------------------------------------------
package lbs_pkg;
  localparam int MaxJoints     = 64;
  localparam int WordsPerJoint = 12;
  localparam int StoreDepth    = MaxJoints * WordsPerJoint;
  localparam int AddrW         = $clog2(StoreDepth);

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_VERTEX = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic        [5:0]  joint_id;
    logic        [3:0]  word_index;
    logic signed [31:0] word_value;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [15:0] weight;
    logic               last_joint;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               overflow;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic       capture;   // latch the request
    logic       rd_en;     // read a matrix word
    logic [3:0] rd_word;   // word within joint
    logic       mul_en;    // multiply the returned word
    logic [1:0] mul_k;     // column of the returned word
    logic [1:0] row;       // row of the returned word
    logic       emit;      // saturate accumulators into the output register
  } lbs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       is_vertex;
    logic       active;    // weight non-zero and joint in range
    logic       last;
  } lbs_sts_t;
endpackage

// ===== sv/lbs_ram.sv =====
// ----------------------------------------------------------------------------
// lbs_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module lbs_ram #(
  parameter int Width = 32,
  parameter int Depth = 768
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end
endmodule

// ===== sv/lbs_datapath.sv =====
// ----------------------------------------------------------------------------
// lbs_datapath
// matrix store, shared multiplier chain, accumulators and output saturation
// ----------------------------------------------------------------------------
module lbs_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  lbs_pkg::in_item_t in_item,
  input  logic              wr_en,
  input  lbs_pkg::lbs_cmd_t cmd,
  output lbs_pkg::lbs_sts_t sts,
  output lbs_pkg::out_item_t res
);
  import lbs_pkg::*;

  in_item_t item_r;
  logic [31:0] rd_data;
  logic [AddrW-1:0] base_r, wr_addr, rd_addr;
  logic        wr_ok;
  logic signed [63:0] prod_r;      // matrix word times position
  logic [1:0]  prow_r;
  logic        pvalid_r, plast_r;
  logic signed [49:0] t_r;         // row sum
  logic        tvalid_r;
  logic signed [66:0] wprod_r;     // row sum times weight
  logic        wvalid_r;
  logic [1:0]  wrow_r;
  logic [63:0] acc_r [3];
  logic signed [31:0] pos_sel;
  logic signed [31:0] mword_r;
  logic [1:0]  mk_r, mrow_r;
  logic        mvalid_r;

  // write address joint*12 + word, as shifts
  assign wr_addr = AddrW'({in_item.joint_id, 3'b000}) + AddrW'({in_item.joint_id, 2'b00})
                 + AddrW'(in_item.word_index);
  assign rd_addr = base_r + AddrW'(cmd.rd_word);

  // loads beyond the last word of a joint are dropped
  assign wr_ok = wr_en && (32'(in_item.word_index) < WordsPerJoint);

  lbs_ram #(.Width(32), .Depth(StoreDepth)) u_store (
    .clk     (clk),
    .wr_en   (wr_ok),
    .wr_addr (wr_addr),
    .wr_data (in_item.word_value),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
      base_r <= AddrW'({in_item.joint_id, 3'b000}) + AddrW'({in_item.joint_id, 2'b00});
    end
  end

  assign sts.is_vertex = item_r.req_type == REQ_VERTEX;
  assign sts.active    = (item_r.weight != '0) && (32'(item_r.joint_id) < MaxJoints);
  assign sts.last      = item_r.last_joint;

  // register the returned word with its tags
  always_ff @(posedge clk) begin
    if (!rst_n) mvalid_r <= 1'b0;
    else        mvalid_r <= cmd.mul_en;
    mword_r <= rd_data;
    mk_r    <= cmd.mul_k;
    mrow_r  <= cmd.row;
  end

  always_comb begin
    case (mk_r)
      2'd0:    pos_sel = item_r.pos_x;
      2'd1:    pos_sel = item_r.pos_y;
      2'd2:    pos_sel = item_r.pos_z;
      default: pos_sel = 32'sd0;
    endcase
  end

  // stage 1: one 32x32 product, offset column passes through as q16.16 scaled
  always_ff @(posedge clk) begin
    if (!rst_n) pvalid_r <= 1'b0;
    else        pvalid_r <= mvalid_r;
    if (mk_r == 2'd3) prod_r <= 64'(mword_r) <<< 16;
    else              prod_r <= mword_r * pos_sel;
    prow_r  <= mrow_r;
    plast_r <= mk_r == 2'd3;
  end

  // stage 2: row sum of floored products
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_r      <= '0;
      tvalid_r <= 1'b0;
    end else begin
      tvalid_r <= pvalid_r && plast_r;
      if (pvalid_r) begin
        if (plast_r) t_r <= '0;
        else         t_r <= t_r + 50'(prod_r >>> 16);
      end
    end
  end

  // stage 3: weight the completed row sum (offset folded in here)
  logic signed [49:0] row_sum;
  assign row_sum = t_r + 50'(prod_r >>> 16);
  always_ff @(posedge clk) begin
    if (!rst_n) wvalid_r <= 1'b0;
    else        wvalid_r <= pvalid_r && plast_r;
    wprod_r <= row_sum * $signed({1'b0, item_r.weight});
    wrow_r  <= prow_r;
  end

  // accumulate floor(t*w / 2^15); clear after emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r[0] <= '0; acc_r[1] <= '0; acc_r[2] <= '0;
    end else if (cmd.emit) begin
      acc_r[0] <= '0; acc_r[1] <= '0; acc_r[2] <= '0;
    end else if (wvalid_r) begin
      acc_r[wrow_r] <= acc_r[wrow_r] + 64'(wprod_r >>> 15);
    end
  end

  function automatic logic [32:0] sat(input logic [63:0] a);
    logic signed [63:0] s;
    s = a;
    if (s > 64'sh7FFFFFFF)       sat = {1'b1, 32'h7FFFFFFF};
    else if (s < -64'sh80000000) sat = {1'b1, 32'h80000000};
    else                         sat = {1'b0, a[31:0]};
  endfunction

  logic [32:0] sx, sy, sz;
  assign sx = sat(acc_r[0]);
  assign sy = sat(acc_r[1]);
  assign sz = sat(acc_r[2]);

  // output register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res.out_x    <= sx[31:0];
      res.out_y    <= sy[31:0];
      res.out_z    <= sz[31:0];
      res.overflow <= sx[32] | sy[32] | sz[32];
    end
  end
endmodule

// ===== sv/lbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbs_ctrl
// sequencer: issues twelve matrix reads, waits for the pipe, emits results
// ----------------------------------------------------------------------------
module lbs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_type,
  output logic              in_stall,
  output logic              wr_en,
  input  logic              out_stall,
  output logic              out_valid,
  input  lbs_pkg::lbs_sts_t sts,
  output lbs_pkg::lbs_cmd_t cmd
);
  import lbs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       rd_q_r;
  logic [3:0] rd_w_r;

  assign in_stall  = state_r != S_IDLE;
  assign accept    = in_valid && !in_stall;
  assign wr_en     = accept && in_req_type == REQ_LOAD;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.rd_word   = cnt_r;
    cmd.mul_en    = rd_q_r;
    cmd.mul_k     = rd_w_r[1:0];
    cmd.row       = rd_w_r[3:2];
    case (state_r)
      S_IDLE: begin
        cmd.capture = accept;
        if (accept && in_req_type == REQ_VERTEX) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cnt_nxt = '0;
        if (sts.active) state_nxt = S_READ;
        else if (sts.last) state_nxt = S_EMIT;
        else state_nxt = S_IDLE;
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        cnt_nxt   = cnt_r + 4'd1;
        if (cnt_r == 4'd11) begin
          cnt_nxt   = '0;
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // read, multiply, sum, weight, accumulate
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd4) state_nxt = sts.last ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // read data is valid in the cycle after the read, tags follow it
  always_ff @(posedge clk) begin
    if (!rst_n) rd_q_r <= 1'b0;
    else        rd_q_r <= cmd.rd_en;
    rd_w_r <= cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule

// ===== sv/linear_blend_skinning.sv =====
// a load writes the matrix store at acceptance; a vertex result is registered at emit
// a vertex contribution stalls the input until its twelve reads through the single matrix
// store read port and the pipe drain are done; a skipped one stalls it through the check
// one load per cycle while idle; reset: synchronous active low, clears control and accumulators
// ----------------------------------------------------------------------------
// linear_blend_skinning
// top level: sequencer and datapath of the skinning block
// ----------------------------------------------------------------------------
`include "linear_blend_skinning_assert.svh"
module linear_blend_skinning (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  lbs_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output lbs_pkg::out_item_t out_data
);
  import lbs_pkg::*;

  lbs_cmd_t cmd;
  lbs_sts_t sts;
  logic     wr_en;

  lbs_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_req_type(in_data.req_type), .in_stall,
    .wr_en, .out_stall, .out_valid, .sts, .cmd
  );

  lbs_datapath u_dp (
    .clk, .rst_n, .in_item(in_data), .wr_en, .cmd(cmd), .sts, .res(out_data)
  );

  `LBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result lost")
  `LBS_ASSERT_IMPL(a_wr_idle, wr_en, !in_stall, "load while busy")
  `LBS_ASSERT_IMPL(a_emit_free, cmd.emit, !(out_valid && out_stall), "result overwritten")
endmodule

// ===== sim/linear_blend_skinning_test.sv =====
// ----------------------------------------------------------------------------
// linear_blend_skinning_test
// loads skinning matrices and streams vertex contributions through the block,
// predicts each blended position in fixed point and checks every result
// ----------------------------------------------------------------------------
module linear_blend_skinning_test;
  import lbs_pkg::*;

  localparam int StallLimit = 5000;
  localparam int RandomRequests = 1250;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  linear_blend_skinning u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // predictor state: matrix words, which were written, and the accumulators
  logic signed [31:0] matrix_word [StoreDepth];
  bit                 word_written [StoreDepth];
  logic        [63:0] blend_acc [3];
  out_item_t          pending_positions [$];

  int mismatches = 0;
  int requests_sent = 0;
  int positions_checked = 0;
  int overflows_seen = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int quiet_cycles = 0;

  // one matrix row applied to the position, scaled by the weight
  function automatic logic [63:0] row_blend(int base, logic signed [31:0] px,
                                            logic signed [31:0] py,
                                            logic signed [31:0] pz,
                                            logic [15:0] w);
    longint             t;
    logic signed [79:0] t_wide;
    logic signed [79:0] w_wide;
    logic signed [79:0] scaled;
    t = longint'(matrix_word[base + 3]);
    t += (longint'(matrix_word[base]) * longint'(px)) >>> 16;
    t += (longint'(matrix_word[base + 1]) * longint'(py)) >>> 16;
    t += (longint'(matrix_word[base + 2]) * longint'(pz)) >>> 16;
    t_wide = t;
    w_wide = {64'd0, w};
    scaled = (t_wide * w_wide) >>> 15;
    return scaled[63:0];
  endfunction

  function automatic logic signed [31:0] clamp_q16(logic [63:0] acc, ref bit ovf);
    longint s;
    s = longint'(acc);
    if (s > 64'sd2147483647) begin
      ovf = 1'b1;
      return 32'sh7fffffff;
    end
    if (s < -64'sd2147483648) begin
      ovf = 1'b1;
      return 32'sh80000000;
    end
    return s[31:0];
  endfunction

  // update the predicted state with one accepted request
  function automatic void predict_skinning(in_item_t r);
    int        base;
    bit        ovf;
    out_item_t pos;
    if (r.req_type == REQ_LOAD) begin
      if (r.word_index < WordsPerJoint) begin
        matrix_word[r.joint_id * WordsPerJoint + r.word_index] = r.word_value;
        word_written[r.joint_id * WordsPerJoint + r.word_index] = 1'b1;
      end
      return;
    end
    if (r.weight != 0 && r.joint_id < MaxJoints) begin
      base = r.joint_id * WordsPerJoint;
      for (int row = 0; row < 3; row++)
        blend_acc[row] += row_blend(base + 4 * row, r.pos_x, r.pos_y, r.pos_z,
                                    r.weight);
    end
    if (r.last_joint) begin
      ovf = 1'b0;
      pos.out_x = clamp_q16(blend_acc[0], ovf);
      pos.out_y = clamp_q16(blend_acc[1], ovf);
      pos.out_z = clamp_q16(blend_acc[2], ovf);
      pos.overflow = ovf;
      pending_positions = {pending_positions, pos};
      blend_acc = '{default: '0};
    end
  endfunction

  // present one request, wait for acceptance, then maybe idle a while
  task automatic send_request(in_item_t r);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (in_stall);
    predict_skinning(r);
    requests_sent++;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic load_word(int joint, int idx, logic [31:0] value, bit last = 1'b0);
    in_item_t r;
    r = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    r.req_type = REQ_LOAD;
    r.joint_id = 6'(joint);
    r.word_index = 4'(idx);
    r.word_value = value;
    r.last_joint = last;
    send_request(r);
  endtask

  task automatic vertex_contrib(int joint, logic [31:0] px, logic [31:0] py,
                                logic [31:0] pz, logic [15:0] w, bit last);
    in_item_t r;
    r = in_item_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    r.req_type = REQ_VERTEX;
    r.joint_id = 6'(joint);
    r.pos_x = px;
    r.pos_y = py;
    r.pos_z = pz;
    r.weight = w;
    r.last_joint = last;
    send_request(r);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'h00010000;
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 18'h3ffff)) - 18'sh1ffff);
    endcase
  endfunction

  function automatic logic [15:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom);
      default: return 16'($urandom_range(1, 32768));
    endcase
  endfunction

  function automatic bit joint_loaded(int joint);
    for (int i = 0; i < WordsPerJoint; i++)
      if (!word_written[joint * WordsPerJoint + i]) return 1'b0;
    return 1'b1;
  endfunction

  task automatic load_joint(int joint);
    for (int i = 0; i < WordsPerJoint; i++) load_word(joint, i, pick_word());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // corner cases: identity, extreme words, zero and large weights, ignored loads
  task automatic test_directed_corners();
    for (int i = 0; i < WordsPerJoint; i++)
      load_word(0, i, (i % 5 == 0) ? 32'h00010000 : 32'h0, i == 3);
    for (int i = 0; i < WordsPerJoint; i++)
      load_word(63, i, i[0] ? 32'h80000000 : 32'h7fffffff);
    load_word(0, 12, 32'hffffffff);
    load_word(0, 15, 32'h12345678);
    vertex_contrib(0, 32'h7fffffff, 32'h80000000, 32'h00018000, 16'd32768, 1'b1);
    vertex_contrib(0, 32'h00010000, 32'h00020000, 32'h00030000, 16'd0, 1'b1);
    vertex_contrib(63, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 16'hffff, 1'b1);
    vertex_contrib(0, 32'h00010000, 32'hffff0000, 32'h0, 16'd16384, 1'b0);
    vertex_contrib(63, 32'h00000001, 32'hffffffff, 32'h0, 16'd16384, 1'b1);
    vertex_contrib(63, 32'h80000000, 32'h80000000, 32'h80000000, 16'd1, 1'b1);
    wait_drained();
  endtask

  // random skinning: matrix reloads, multi-joint vertices and some noise
  task automatic test_random_skinning(int count);
    int stop_at;
    int joint;
    int n;
    bit small_pos;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      joint = $urandom_range(0, MaxJoints - 1);
      n = $urandom_range(0, 99);
      if (n < 15 || !joint_loaded(joint)) begin
        if (n < 15 || $urandom_range(0, 3) == 0) load_joint(joint);
      end else if (n < 25) begin
        load_word(joint, $urandom_range(0, 15), pick_word(), $urandom_range(0, 1) == 1);
      end else begin
        n = $urandom_range(1, 4);
        small_pos = $urandom_range(0, 3) != 0;
        for (int c = 0; c < n; c++) begin
          do joint = $urandom_range(0, MaxJoints - 1); while (!joint_loaded(joint));
          if (small_pos)
            vertex_contrib(joint, 32'($signed($urandom_range(0, 20'hfffff)) - 20'sh7ffff),
                           32'($signed($urandom_range(0, 20'hfffff)) - 20'sh7ffff),
                           32'($signed($urandom_range(0, 20'hfffff)) - 20'sh7ffff),
                           pick_weight(), c == n - 1);
          else
            vertex_contrib(joint, $urandom, $urandom, $urandom, pick_weight(),
                           c == n - 1);
        end
      end
    end
    in_valid <= 1'b0;
    wait_drained();
  endtask

  // compare each blended position against the oldest prediction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_positions.size() == 0) begin
          $error("unexpected position x=%0d y=%0d z=%0d", out_data.out_x,
                 out_data.out_y, out_data.out_z);
          mismatches++;
        end else begin
          out_item_t want;
          want = pending_positions.pop_front();
          if (out_data.out_x !== want.out_x) begin
            $error("out_x expected %0d actual %0d", want.out_x, out_data.out_x);
            mismatches++;
          end
          if (out_data.out_y !== want.out_y) begin
            $error("out_y expected %0d actual %0d", want.out_y, out_data.out_y);
            mismatches++;
          end
          if (out_data.out_z !== want.out_z) begin
            $error("out_z expected %0d actual %0d", want.out_z, out_data.out_z);
            mismatches++;
          end
          if (out_data.overflow !== want.overflow) begin
            $error("overflow expected %0b actual %0b", want.overflow,
                   out_data.overflow);
            mismatches++;
          end
          if (want.overflow) overflows_seen++;
          positions_checked++;
        end
      end
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // watchdog on cycles with no request or position moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    for (int i = 0; i < StoreDepth; i++) word_written[i] = 1'b0;
    blend_acc = '{default: '0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    tx_idle_pct = 12;
    rx_idle_pct = 85;
    test_random_skinning(RandomRequests / 3);
    tx_idle_pct = 85;
    rx_idle_pct = 12;
    test_random_skinning(RandomRequests / 3);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_skinning(RandomRequests - 2 * (RandomRequests / 3));
    $display("covered %0d requests, %0d blended positions checked, %0d saturated",
             requests_sent, positions_checked, overflows_seen);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end
endmodule
